@@ rtl/pma_pkg.sv @@
// Shared constants and codes for the page map allocator.
package pma_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 2048;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // Per-page map states
  localparam logic [1:0] PG_FREE     = 2'd0;
  localparam logic [1:0] PG_TAKEN    = 2'd1;
  localparam logic [1:0] PG_RESERVED = 2'd2;

  // Input item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  // Result status codes
  localparam logic [2:0] RS_ALLOCATED = 3'd0;
  localparam logic [2:0] RS_REFUSED   = 3'd1;
  localparam logic [2:0] RS_NO_MEMORY = 3'd2;
  localparam logic [2:0] RS_FREED     = 3'd3;
  localparam logic [2:0] RS_IGNORED   = 3'd4;
  localparam logic [2:0] RS_CLEARED   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  localparam logic [31:0] POOL_BASE_RST  = 32'h0010_0000;
  localparam logic [11:0] POOL_PAGES_RST = 12'd2048;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

endpackage

@@ rtl/pma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pma_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/page_map_allocator.sv @@
// Page map allocator top level: first-fit single-page allocator over a page state map.
//
// One item is handled at a time; s_axis_tready is high only while the block is idle.
// A clear item sweeps the whole map, one entry per cycle.
// An allocate scans the map from page 1 through one RAM read port, one entry per
// cycle, up to the last usable page; a refused allocate skips the scan. A free
// does a range check, one map read and a write back of a taken page, and ends
// after the range check when it fails. After reset the block runs the same
// clearing sweep before it takes any item; configuration writes are taken at
// any time. The result sits in an output register, so the next item can be
// taken while it waits on m_axis_tready.
module page_map_allocator #(
  parameter int unsigned MAX_PAGES  = pma_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = pma_pkg::PAGE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] kind, [17:2] page_count, [49:18] address, [55:50] zero
  input  logic [pma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] page_address, [34:32] status, [39:35] zero
  output logic [pma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import pma_pkg::*;

  localparam int unsigned IW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);
  localparam int unsigned SHIFT = $clog2(PAGE_BYTES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FCHK = 3'd4;
  localparam logic [2:0] ST_FRD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // Control state
  logic [2:0]    state_q, state_d;
  logic          report_q, report_d;
  logic          chk_v_q, chk_v_d;
  logic          m_valid_q, m_valid_d;
  logic [31:0]   pool_base_q;
  logic [11:0]   pool_pages_q;

  // Work registers
  logic [1:0]    kind_q;
  logic [15:0]   count_q;
  logic [31:0]   addr_q;
  logic [PW-1:0] n_q, n_d;
  logic [PW-1:0] a_q, a_d;
  logic [IW-1:0] chk_q, chk_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic [31:0]   res_addr_q, res_addr_d;
  logic [2:0]    res_status_q, res_status_d;
  logic [31:0]   out_addr_q;
  logic [2:0]    out_status_q;
  logic          out_load;

  // Map RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;

  pma_ram #(
    .WIDTH(2),
    .DEPTH(MAX_PAGES)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Usable pages: min(pool_pages, MAX_PAGES, pages that fit below 2^32)
  logic [32:0] fit;
  logic [32:0] lim;
  logic [32:0] usable;

  always_comb begin
    fit    = (33'h1_0000_0000 - {1'b0, pool_base_q}) >> SHIFT;
    lim    = (33'(pool_pages_q) > 33'(MAX_PAGES)) ? 33'(MAX_PAGES) : 33'(pool_pages_q);
    usable = (fit < lim) ? fit : lim;
  end

  // Free address check
  logic [31:0] off;
  logic [31:0] fpage;
  logic        free_ok;

  always_comb begin
    off     = addr_q - pool_base_q;
    fpage   = off >> SHIFT;
    free_ok = (addr_q >= pool_base_q) && (off[SHIFT-1:0] == '0) &&
              (fpage != '0) && (fpage < 32'(n_q));
  end

  logic [31:0] found_addr;
  assign found_addr = pool_base_q + (32'(chk_q) << SHIFT);

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    report_d     = report_q;
    chk_v_d      = chk_v_q;
    n_d          = n_q;
    a_d          = a_q;
    chk_d        = chk_q;
    clr_d        = clr_q;
    fidx_d       = fidx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_q;
    ram_wdata    = PG_FREE;
    ram_raddr    = a_q[IW-1:0];
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        n_d        = usable[PW-1:0];
        res_addr_d = '0;
        unique case (kind_q)
          KIND_CLEAR: begin
            report_d = 1'b1;
            clr_d    = '0;
            state_d  = ST_CLR;
          end
          KIND_ALLOC: begin
            if (count_q > 16'd1) begin
              res_status_d = RS_REFUSED;
              state_d      = ST_DONE;
            end else begin
              a_d     = PW'(1);
              chk_v_d = 1'b0;
              state_d = ST_SCAN;
            end
          end
          KIND_FREE: begin
            state_d = ST_FCHK;
          end
          default: begin
            res_status_d = RS_IGNORED;
            state_d      = ST_DONE;
          end
        endcase
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? PG_RESERVED : PG_FREE;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(MAX_PAGES - 1)) begin
          if (report_q) begin
            report_d     = 1'b0;
            res_addr_d   = '0;
            res_status_d = RS_CLEARED;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        // Read of page a issued this cycle; data of page chk checked this cycle
        if (chk_v_q && (ram_rdata == PG_FREE)) begin
          ram_we       = 1'b1;
          ram_waddr    = chk_q;
          ram_wdata    = PG_TAKEN;
          res_addr_d   = found_addr;
          res_status_d = RS_ALLOCATED;
          state_d      = ST_DONE;
        end else if (a_q < n_q) begin
          ram_raddr = a_q[IW-1:0];
          chk_d     = a_q[IW-1:0];
          chk_v_d   = 1'b1;
          a_d       = a_q + PW'(1);
        end else begin
          res_addr_d   = '0;
          res_status_d = RS_NO_MEMORY;
          state_d      = ST_DONE;
        end
      end
      ST_FCHK: begin
        if (free_ok) begin
          ram_raddr = fpage[IW-1:0];
          fidx_d    = fpage[IW-1:0];
          state_d   = ST_FRD;
        end else begin
          res_status_d = RS_IGNORED;
          state_d      = ST_DONE;
        end
      end
      ST_FRD: begin
        if (ram_rdata == PG_TAKEN) begin
          ram_we       = 1'b1;
          ram_waddr    = fidx_q;
          ram_wdata    = PG_FREE;
          res_status_d = RS_FREED;
        end else begin
          res_status_d = RS_IGNORED;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      report_q     <= 1'b0;
      chk_v_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      clr_q        <= '0;
      pool_base_q  <= POOL_BASE_RST;
      pool_pages_q <= POOL_PAGES_RST;
    end else begin
      state_q   <= state_d;
      report_q  <= report_d;
      chk_v_q   <= chk_v_d;
      m_valid_q <= m_valid_d;
      clr_q     <= clr_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
          CFG_POOL_PAGES: pool_pages_q <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tdata[1:0];
      count_q <= s_axis_tdata[17:2];
      addr_q  <= s_axis_tdata[49:18];
    end
    n_q          <= n_d;
    a_q          <= a_d;
    chk_q        <= chk_d;
    fidx_q       <= fidx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, out_status_q, out_addr_q};

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the page map allocator: directed and random request streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pma_pkg::*;

  localparam int unsigned MAX_PAGES   = MAX_PAGES_DEF;
  localparam int unsigned PAGE_BYTES  = PAGE_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] page_address;
    logic [2:0]  status;
  } page_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_idx_i     = 1'b0;
  logic [31:0]            cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predicted block state
  logic [1:0]  page_map_model [MAX_PAGES];
  logic [31:0] base_model  = POOL_BASE_RST;
  logic [11:0] pages_model = POOL_PAGES_RST;

  page_result_t expected_results [$];
  int          fail_count    = 0;
  int          requests_sent = 0;
  int          status_tally [6];
  int unsigned cycle_count   = 0;
  int          stall_left    = 0;
  bit          idle_on       = 1'b1;

  page_map_allocator #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void clear_page_model();
    for (int p = 0; p < MAX_PAGES; p++) page_map_model[p] = PG_FREE;
    page_map_model[0] = PG_RESERVED;
  endfunction

  // Advances the map model by one request and returns the result it must produce.
  function automatic page_result_t predict_page_result(input logic [1:0] kind,
                                                       input logic [15:0] count,
                                                       input logic [31:0] addr);
    page_result_t res;
    longint unsigned usable, fit, off, pg, full;
    bit found;
    res.page_address = '0;
    res.status       = RS_IGNORED;
    // pages past MAX_PAGES or past the top of the address space do not exist
    usable = pages_model;
    fit    = (64'h1_0000_0000 - longint'(base_model)) / PAGE_BYTES;
    if (usable > MAX_PAGES) usable = MAX_PAGES;
    if (usable > fit) usable = fit;
    case (kind)
      KIND_CLEAR: begin
        clear_page_model();
        res.status = RS_CLEARED;
      end
      KIND_ALLOC: begin
        if (count > 16'd1) begin
          res.status = RS_REFUSED;
        end else begin
          res.status = RS_NO_MEMORY;
          found = 1'b0;
          for (pg = 1; pg < usable && !found; pg++) begin
            if (page_map_model[pg] == PG_FREE) begin
              page_map_model[pg] = PG_TAKEN;
              full = longint'(base_model) + pg * PAGE_BYTES;
              res.page_address = full[31:0];
              res.status = RS_ALLOCATED;
              found = 1'b1;
            end
          end
        end
      end
      KIND_FREE: begin
        if (addr >= base_model) begin
          off = addr - base_model;
          pg  = off / PAGE_BYTES;
          if (off % PAGE_BYTES == 0 && pg >= 1 && pg < usable &&
              page_map_model[pg] == PG_TAKEN) begin
            page_map_model[pg] = PG_FREE;
            res.status = RS_FREED;
          end
        end
      end
      default: ;
    endcase
    status_tally[res.status]++;
    return res;
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [15:0] count,
                              input logic [31:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, addr, count, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_page_result(kind, count, addr));
    requests_sent++;
  endtask

  // Every request yields one result, so an empty queue means the block is idle.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pool(input logic [31:0] base, input logic [11:0] pages);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_POOL_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    // upper bits of the page-count write carry junk; only [11:0] counts
    cfg_idx_i   <= CFG_POOL_PAGES;
    cfg_wdata_i <= {20'($urandom), pages};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_model  = base;
    pages_model = pages;
  endtask

  // Result checker and sink-side backpressure
  always @(posedge clk_i) begin : check_results
    page_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with none expected", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== want.page_address)
          report_mismatch($sformatf("page_address expected %h, got %h",
                                    want.page_address, m_axis_tdata[31:0]));
        if (m_axis_tdata[34:32] !== want.status)
          report_mismatch($sformatf("status expected %0d, got %0d (page_address %h)",
                                    want.status, m_axis_tdata[34:32], want.page_address));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Reset register values: zero-page request, refusals, frees ignored as not taken, page 0, unaligned or below base.
  task automatic test_alloc_free_basics();
    send_request(KIND_ALLOC, 16'd0, '0);
    send_request(KIND_ALLOC, 16'd1, '0);
    send_request(KIND_ALLOC, 16'd2, '0);
    send_request(KIND_ALLOC, 16'hFFFF, '0);
    send_request(KIND_FREE, 16'd0, 32'h0010_1000);
    send_request(KIND_FREE, 16'd0, 32'h0010_1000);
    send_request(KIND_FREE, 16'd0, 32'h0010_0000);
    send_request(KIND_FREE, 16'd0, 32'h0010_2800);
    send_request(KIND_FREE, 16'd0, 32'h000F_F000);
    send_request(KIND_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, 16'd1, '0);
  endtask

  // Pool cut by the top of the address space, tiny pools, unaligned base.
  task automatic test_pool_limits();
    set_pool(32'hFFFF_E000, 12'hFFF);
    send_request(KIND_CLEAR, 16'd0, '0);
    send_request(KIND_ALLOC, 16'd1, '0);
    send_request(KIND_ALLOC, 16'd0, '0);
    send_request(KIND_FREE, 16'd0, 32'hFFFF_F000);
    set_pool(32'h0000_0000, 12'd1);
    send_request(KIND_ALLOC, 16'd1, '0);
    set_pool(32'h0000_0000, 12'd0);
    send_request(KIND_ALLOC, 16'd0, '0);
    set_pool(32'h1234_5678, 12'd3);
    send_request(KIND_ALLOC, 16'd1, '0);
    send_request(KIND_FREE, 16'd0, 32'h1234_6000);
    send_request(KIND_FREE, 16'd0, 32'h1234_6678);
  endtask

  // Shrinking the pool hides taken pages without touching the map.
  task automatic test_pool_resize();
    set_pool(32'h4000_0000, 12'd6);
    repeat (3) send_request(KIND_ALLOC, 16'd1, '0);
    set_pool(32'h4000_0000, 12'd2);
    send_request(KIND_FREE, 16'd0, 32'h4000_3000);
    send_request(KIND_ALLOC, 16'd0, '0);
    set_pool(32'h4000_0000, 12'd6);
    send_request(KIND_FREE, 16'd0, 32'h4000_3000);
  endtask

  task automatic test_random_traffic(input int phase, input int num_items);
    int unsigned taken [$];
    logic [31:0] base, addr;
    logic [11:0] pages;
    int r;
    case (phase)
      0: begin base = $urandom & 32'hFFFF_F000; pages = 12'($urandom_range(2, 16)); end
      1: begin base = $urandom;                 pages = 12'($urandom_range(2, 32)); end
      2: begin base = 32'hFFFF_F000 - ($urandom_range(0, 12) << 12); pages = 12'($urandom); end
      3: begin base = $urandom & 32'h7FFF_F000; pages = 12'd2048; end
      default: begin base = $urandom & 32'hFFFF_F000; pages = 12'($urandom_range(2, 64)); end
    endcase
    set_pool(base, pages);
    repeat (num_items) begin
      r = $urandom_range(0, 99);
      if (r >= 45 && r < 75) begin
        // return a page the map holds as taken, possibly beyond a shrunk pool
        taken.delete();
        for (int p = 1; p < MAX_PAGES; p++)
          if (page_map_model[p] == PG_TAKEN) taken.push_back(p);
        if (taken.size() == 0) begin
          send_request(KIND_ALLOC, 16'($urandom_range(0, 1)), $urandom);
        end else begin
          addr = base_model + taken[$urandom_range(0, taken.size() - 1)] * PAGE_BYTES;
          send_request(KIND_FREE, 16'($urandom), addr);
        end
      end else if (r >= 75 && r < 83) begin
        case ($urandom_range(0, 2))
          0: addr = $urandom;
          1: addr = base_model + $urandom_range(0, 40) * PAGE_BYTES + $urandom_range(0, 4095);
          default: addr = base_model - $urandom_range(0, 3) * PAGE_BYTES;
        endcase
        send_request(KIND_FREE, 16'($urandom), addr);
      end else if (r >= 83 && r < 90) begin
        send_request(KIND_ALLOC, 16'($urandom_range(2, 65535)), $urandom);
      end else if (r >= 90 && r < 93) begin
        send_request(KIND_CLEAR, 16'($urandom), $urandom);
      end else if (r >= 93 && r < 96) begin
        send_request(KIND_UNUSED, 16'($urandom), $urandom);
      end else if (r >= 96) begin
        send_request(KIND_ALLOC, 16'($urandom), $urandom);
      end else begin
        send_request(KIND_ALLOC, 16'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  initial begin
    clear_page_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_alloc_free_basics();
    test_pool_limits();
    test_pool_resize();
    for (int ph = 0; ph < 5; ph++) test_random_traffic(ph, 44);
    idle_on = 1'b0;
    test_random_traffic(5, 44);
    settle_block();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests in %0d cycles, %0d mismatches", requests_sent, cycle_count,
             fail_count);
    $display("Results: %0d allocated, %0d refused, %0d out of memory, %0d freed, %0d ignored, %0d cleared",
             status_tally[RS_ALLOCATED], status_tally[RS_REFUSED], status_tally[RS_NO_MEMORY],
             status_tally[RS_FREED], status_tally[RS_IGNORED], status_tally[RS_CLEARED]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pma_pkg.sv
rtl/pma_ram.sv
rtl/page_map_allocator.sv
dv/testbench.sv
